// ----- rtl/core/efsd_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// efsd_pkg
// Shared constants, types and helpers for the earliest-free server dispatch.
// ----------------------------------------------------------------------------
package efsd_pkg;

  localparam int LANES   = 16;
  localparam int IDX_W   = (LANES > 1) ? $clog2(LANES) : 1;
  localparam int CNT_W   = $clog2(LANES + 1);
  localparam int TIME_W  = 32;
  localparam int DUR_W   = 16;
  localparam int SRV_W   = 5;
  localparam int CFG_W   = 5;

  localparam logic MODE_CLEAR  = 1'b0;
  localparam logic MODE_ASSIGN = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic              rd_en;
    logic [IDX_W-1:0]  rd_addr;
    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    logic [TIME_W-1:0] wr_data;
    logic              clr;
  } store_req_t;

  // register value clamped to 1..LANES
  function automatic logic [CNT_W-1:0] active_count(input logic [CFG_W-1:0] v);
    logic [31:0] w;
    w = 32'(v);
    if (w < 32'd1) begin
      w = 32'd1;
    end else if (w > 32'(LANES)) begin
      w = 32'(LANES);
    end
    return w[CNT_W-1:0];
  endfunction

  // server number from 1, masked to the field width
  function automatic logic [SRV_W-1:0] srv_num(input logic [IDX_W-1:0] idx);
    logic [31:0] w;
    w = 32'(idx) + 32'd1;
    return w[SRV_W-1:0];
  endfunction

endpackage
`default_nettype wire

// ----- rtl/core/efsd_time_store.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// efsd_time_store
// Free-at time memory, one read and one write port, registered read data.
// Per-entry valid bits give zero for entries not written since reset or clear.
// ----------------------------------------------------------------------------
module efsd_time_store
  import efsd_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire store_req_t        req,
  output logic [TIME_W-1:0]      rd_data
);

  logic [TIME_W-1:0] mem [LANES];
  logic [LANES-1:0]  vbits;
  logic [TIME_W-1:0] dq;
  logic              vq;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      dq <= mem[req.rd_addr];
      vq <= vbits[req.rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst || req.clr) begin
      vbits <= '0;
    end else if (req.wr_en) begin
      vbits[req.wr_addr] <= 1'b1;
    end
  end

  assign rd_data = vq ? dq : '0;

endmodule
`default_nettype wire

// ----- rtl/core/earliest_free_server_dispatch_top.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// earliest_free_server_dispatch_top
// Dispatches jobs to the server with the earliest free-at time.
// ----------------------------------------------------------------------------
// An assign word is accepted in IDLE and then scans the n servers in use
// (1..16): the free-at time memory is read one entry a cycle while the
// least and second-least times are tracked, then the DONE state, once the
// output register is free, adds the duration, writes the entry back and
// forms the result. A clear word goes straight to DONE. Input is taken one
// word at a time; a finished result waits in the output register while
// the next word is accepted. No clearing pass is needed after reset.
module earliest_free_server_dispatch_top
  import efsd_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [CFG_W-1:0]  cfg_data,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic              mode,
  input  wire logic [DUR_W-1:0]  job_duration,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [SRV_W-1:0]       assigned_server,
  output logic [SRV_W-1:0]       next_server,
  output logic [TIME_W-1:0]      assigned_free_time,
  output logic                   saturated
);

  state_t            state, state_next;
  logic [CFG_W-1:0]  servers_in_use;
  logic [CNT_W-1:0]  n_act;
  logic [CNT_W-1:0]  cnt;
  logic              rd_pend;
  logic [IDX_W-1:0]  rd_idx;
  logic              mode_q;
  logic [DUR_W-1:0]  dur_q;
  logic [IDX_W-1:0]  best_idx, sec_idx;
  logic [TIME_W-1:0] best_val, sec_val;
  logic              sec_vld;
  logic [TIME_W-1:0] rd_data;
  store_req_t        req;
  logic              in_acc, slot_free, issue, finish;
  logic [TIME_W:0]   sum;
  logic              sat_c;
  logic [TIME_W-1:0] new_time;
  logic [IDX_W-1:0]  nxt_idx;

  assign cfg_ready = 1'b1;
  assign n_act     = active_count(servers_in_use);
  assign in_acc    = in_valid && !in_stall;
  assign slot_free = !out_valid || !out_stall;
  assign issue     = (state == ST_SCAN) && (cnt < n_act);

  efsd_time_store u_store (
    .clk     (clk),
    .rst     (rst),
    .req     (req),
    .rd_data (rd_data)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_acc) begin
          state_next = (mode == MODE_ASSIGN) ? ST_SCAN : ST_DONE;
        end
      end
      ST_SCAN: begin
        if (cnt == n_act) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (slot_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_stall    = 1'b1;
    finish      = 1'b0;
    req.rd_en   = 1'b0;
    req.rd_addr = cnt[IDX_W-1:0];
    req.wr_en   = 1'b0;
    req.wr_addr = best_idx;
    req.wr_data = new_time;
    req.clr     = 1'b0;
    case (state)
      ST_IDLE: in_stall = 1'b0;
      ST_SCAN: req.rd_en = issue;
      ST_DONE: begin
        finish    = slot_free;
        req.wr_en = slot_free && (mode_q == MODE_ASSIGN);
        req.clr   = slot_free && (mode_q == MODE_CLEAR);
      end
      default: in_stall = 1'b1;
    endcase
  end

  // update of the chosen server and the one free next
  always_comb begin
    sum      = {1'b0, best_val} + (TIME_W + 1)'(dur_q);
    sat_c    = sum[TIME_W];
    new_time = sat_c ? '1 : sum[TIME_W-1:0];
    nxt_idx  = best_idx;
    if (sec_vld) begin
      if (sec_val < new_time) begin
        nxt_idx = sec_idx;
      end else if (sec_val == new_time && sec_idx < best_idx) begin
        nxt_idx = sec_idx;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      servers_in_use <= CFG_W'(1);
      out_valid      <= 1'b0;
      rd_pend        <= 1'b0;
    end else begin
      state   <= state_next;
      rd_pend <= issue;
      if (cfg_valid && cfg_ready) begin
        servers_in_use <= cfg_data;
      end
      if (finish) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      mode_q <= mode;
      dur_q  <= job_duration;
      cnt    <= '0;
    end else if (issue) begin
      cnt <= cnt + CNT_W'(1);
    end
    if (issue) begin
      rd_idx <= cnt[IDX_W-1:0];
    end
    if (rd_pend) begin
      if (rd_idx == '0) begin
        best_idx <= rd_idx;
        best_val <= rd_data;
        sec_vld  <= 1'b0;
      end else if (rd_data < best_val) begin
        sec_idx  <= best_idx;
        sec_val  <= best_val;
        sec_vld  <= 1'b1;
        best_idx <= rd_idx;
        best_val <= rd_data;
      end else if (!sec_vld || rd_data < sec_val) begin
        sec_idx <= rd_idx;
        sec_val <= rd_data;
        sec_vld <= 1'b1;
      end
    end
    if (finish) begin
      if (mode_q == MODE_ASSIGN) begin
        assigned_server    <= srv_num(best_idx);
        next_server        <= srv_num(nxt_idx);
        assigned_free_time <= new_time;
        saturated          <= sat_c;
      end else begin
        assigned_server    <= '0;
        next_server        <= srv_num('0);
        assigned_free_time <= '0;
        saturated          <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/efsd_checker.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// efsd_checker
// Port-level checks on the dispatch block, bound to the top level.
// ----------------------------------------------------------------------------
module efsd_checker
  import efsd_pkg::*;
(
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              in_valid,
  input wire logic              in_stall,
  input wire logic              out_valid,
  input wire logic              out_stall,
  input wire logic [SRV_W-1:0]  assigned_server,
  input wire logic [SRV_W-1:0]  next_server,
  input wire logic [TIME_W-1:0] assigned_free_time,
  input wire logic              saturated
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(assigned_free_time)
      && $stable(assigned_server) && $stable(next_server))
    else $error("result word changed while stalled");

  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken while previous word in flight");

  a_clear: assert property (@(posedge clk) disable iff (rst)
    out_valid && assigned_server == '0 |->
      next_server == SRV_W'(1) && assigned_free_time == '0 && !saturated)
    else $error("clear result malformed");

  a_sat: assert property (@(posedge clk) disable iff (rst)
    out_valid && saturated |-> assigned_free_time == '1 && assigned_server != '0)
    else $error("saturation flag without clamped time");

endmodule

bind earliest_free_server_dispatch_top efsd_checker u_efsd_checker (
  .clk                (clk),
  .rst                (rst),
  .in_valid           (in_valid),
  .in_stall           (in_stall),
  .out_valid          (out_valid),
  .out_stall          (out_stall),
  .assigned_server    (assigned_server),
  .next_server        (next_server),
  .assigned_free_time (assigned_free_time),
  .saturated          (saturated)
);
`default_nettype wire
